>>> rtl/core/ugas_pkg.sv
// shared constants, codes and types of the undirected graph adjacency store
// no dependencies; compile first
package ugas_pkg;

    localparam int NUM_VERTICES = 64;
    localparam int ROWS_USED    = (NUM_VERTICES < 64) ? NUM_VERTICES : 64;
    localparam int ADDR_W       = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;

    localparam int CMD_W  = 2;
    localparam int VTX_W  = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;
    localparam int EDGE_W = 12;
    localparam int AVG_W  = 8;

    // 2 * edge count, dividend of the average
    localparam int DIVD_W    = EDGE_W + 1;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    localparam int WORD_W = CNT_W + ROWS_USED;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 2'd0,
        CMD_QUERY_ADJ = 2'd1,
        CMD_QUERY_DEG = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WRB,
        S_DIV
    } state_t;

    // one memory word: degree of the vertex and its adjacency row
    typedef struct packed {
        logic [CNT_W-1:0]     degree;
        logic [ROWS_USED-1:0] row;
    } row_word_t;

endpackage

>>> rtl/core/ugas_if.sv
// request and response channel interfaces of the adjacency store
// depends on ugas_pkg
interface ugas_req_if;
    logic                        valid;
    logic                        ready;
    logic [ugas_pkg::CMD_W-1:0]  cmd;
    logic [ugas_pkg::VTX_W-1:0]  vertex_a;
    logic [ugas_pkg::VTX_W-1:0]  vertex_b;

    modport source (output valid, output cmd, output vertex_a, output vertex_b, input ready);
    modport sink   (input valid, input cmd, input vertex_a, input vertex_b, output ready);
endinterface

interface ugas_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ugas_pkg::STAT_W-1:0] status;
    logic                        are_adjacent;
    logic [ugas_pkg::CNT_W-1:0]  degree_of_a;
    logic [ugas_pkg::EDGE_W-1:0] edge_total;
    logic [ugas_pkg::CNT_W-1:0]  max_degree;
    logic [ugas_pkg::CNT_W-1:0]  self_loop_total;
    logic [ugas_pkg::AVG_W-1:0]  average_degree;

    modport source (output valid, output status, output are_adjacent, output degree_of_a,
                    output edge_total, output max_degree, output self_loop_total,
                    output average_degree, input ready);
    modport sink   (input valid, input status, input are_adjacent, input degree_of_a,
                    input edge_total, input max_degree, input self_loop_total,
                    input average_degree, output ready);
endinterface

>>> rtl/core/ugas_ram.sv
// generic synchronous ram, one write port and two registered read ports
// no dependencies
module ugas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem_reg[raddr_a];
            rd_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> rtl/core/undirected_graph_adjacency_store_top.sv
// top level of the undirected graph adjacency store
// depends on ugas_pkg, ugas_if (ugas_req_if, ugas_rsp_if) and ugas_ram
//
//   channel   dir  handshake          payload
//   req       in   valid / ready      cmd, vertex_a, vertex_b
//   rsp       out  valid / ready      status, are_adjacent, degree_of_a, edge_total,
//                                     max_degree, self_loop_total, average_degree
//   cfg       in   cfg_we             cfg_wdata (vertex_count)
//
// a request is accepted in S_IDLE together with its memory read, then S_EXEC updates and
// writes row a; adding an edge between two distinct vertices adds S_WRB for the write of
// row b, since the row memory has a single write port
// a write of vertex_count while idle or dividing starts a restoring divide of 2 * edge
// count by the vertex count in use; req.ready stays low during it
// reset and the clear command empty the store through per-row valid bits
// a result waiting on rsp holds the block in the update cycle until rsp.ready
module undirected_graph_adjacency_store_top (
    input  logic                       clk,
    input  logic                       rst_n,
    ugas_req_if.sink                   req,
    ugas_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic [ugas_pkg::CNT_W-1:0] cfg_wdata
);

    import ugas_pkg::*;

    // control state
    state_t               state_reg, state_next;
    logic [ROWS_USED-1:0] valid_reg, valid_next;
    logic [EDGE_W-1:0]    edge_reg, edge_next;
    logic [CNT_W-1:0]     max_reg, max_next;
    logic [CNT_W-1:0]     loop_reg, loop_next;
    logic [CNT_W-1:0]     vcount_reg;
    logic                 out_valid_reg, out_valid_next;

    // running quotient and remainder of 2 * edges / vertex count
    logic [DIVD_W-1:0]    avg_q_reg, avg_q_next;
    logic [CNT_W-1:0]     avg_r_reg, avg_r_next;
    logic [DIVD_W-1:0]    dvd_reg, dvd_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // request held during its execution
    cmd_t                 cmd_reg;
    logic [VTX_W-1:0]     a_reg;
    logic [VTX_W-1:0]     b_reg;

    // result register
    status_t              status_reg;
    logic                 adj_reg;
    logic [CNT_W-1:0]     deg_reg;
    logic [EDGE_W-1:0]    edge_out_reg;
    logic [CNT_W-1:0]     max_out_reg;
    logic [CNT_W-1:0]     loop_out_reg;
    logic [AVG_W-1:0]     avg_out_reg;

    // memory port
    logic                 ram_re;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    row_word_t            ram_wdata;
    logic [WORD_W-1:0]    rdata_a;
    logic [WORD_W-1:0]    rdata_b;

    // datapath
    logic [CNT_W-1:0]     n_eff;
    logic [ADDR_W-1:0]    a_idx;
    logic [ADDR_W-1:0]    b_idx;
    logic                 a_ok;
    logic                 b_ok;
    row_word_t            word_a;
    row_word_t            word_b;
    row_word_t            word_a_new;
    row_word_t            word_b_new;
    logic                 bit_ab;
    logic [CNT_W-1:0]     deg_a_inc;
    logic [CNT_W-1:0]     deg_b_inc;
    logic [CNT_W-1:0]     max_add;
    logic [CNT_W:0]       inc_t0;
    logic [CNT_W:0]       inc_t1;
    logic [CNT_W:0]       inc_t2;
    logic [DIVD_W-1:0]    inc_q;
    logic [CNT_W:0]       div_sh;
    logic                 div_ge;
    logic [CNT_W:0]       div_rem;
    logic                 out_free;
    logic                 load_out;
    status_t              status_new;
    logic                 adj_new;
    logic [CNT_W-1:0]     deg_new;
    logic [AVG_W-1:0]     avg_sat;

    ugas_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS_USED)
    ) u_rows (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (req.vertex_a[ADDR_W-1:0]),
        .raddr_b (req.vertex_b[ADDR_W-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // vertex count in use, clamped to 1 .. rows available
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (vcount_reg > CNT_W'(ROWS_USED))
        begin
            n_eff = CNT_W'(ROWS_USED);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !cfg_we;
    assign ram_re    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign a_idx = a_reg[ADDR_W-1:0];
    assign b_idx = b_reg[ADDR_W-1:0];
    assign a_ok  = {1'b0, a_reg} < n_eff;
    assign b_ok  = {1'b0, b_reg} < n_eff;

    // a row without its valid bit reads as empty
    assign word_a = valid_reg[a_idx] ? row_word_t'(rdata_a) : '0;
    assign word_b = valid_reg[b_idx] ? row_word_t'(rdata_b) : '0;
    assign bit_ab = word_a.row[b_idx];

    assign deg_a_inc = word_a.degree + CNT_W'(1);
    assign deg_b_inc = word_b.degree + CNT_W'(1);

    assign word_a_new.degree = deg_a_inc;
    assign word_a_new.row    = word_a.row | ({{(ROWS_USED-1){1'b0}}, 1'b1} << b_idx);
    assign word_b_new.degree = deg_b_inc;
    assign word_b_new.row    = word_b.row | ({{(ROWS_USED-1){1'b0}}, 1'b1} << a_idx);

    // new maximum after an edge add, row b only counts for distinct vertices
    always_comb
    begin
        max_add = max_reg;
        if (deg_a_inc > max_add)
        begin
            max_add = deg_a_inc;
        end
        if ((a_reg != b_reg) && (deg_b_inc > max_add))
        begin
            max_add = deg_b_inc;
        end
    end

    // 2 * edges grows by 2: at most two corrections of the remainder
    always_comb
    begin
        inc_q  = avg_q_reg;
        inc_t0 = {1'b0, avg_r_reg} + (CNT_W+1)'(2);
        inc_t1 = inc_t0;
        if (inc_t0 >= {1'b0, n_eff})
        begin
            inc_t1 = inc_t0 - {1'b0, n_eff};
            inc_q  = inc_q + DIVD_W'(1);
        end
        inc_t2 = inc_t1;
        if (inc_t1 >= {1'b0, n_eff})
        begin
            inc_t2 = inc_t1 - {1'b0, n_eff};
            inc_q  = inc_q + DIVD_W'(1);
        end
    end

    // restoring divide step
    assign div_sh  = {avg_r_reg, dvd_reg[DIVD_W-1]};
    assign div_ge  = div_sh >= {1'b0, n_eff};
    assign div_rem = div_ge ? (div_sh - {1'b0, n_eff}) : div_sh;

    assign avg_sat = (|avg_q_next[DIVD_W-1:AVG_W]) ? {AVG_W{1'b1}} : avg_q_next[AVG_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        edge_next      = edge_reg;
        max_next       = max_reg;
        loop_next      = loop_reg;
        avg_q_next     = avg_q_reg;
        avg_r_next     = avg_r_reg;
        dvd_next       = dvd_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        load_out       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = a_idx;
        ram_wdata      = word_a_new;
        status_new     = ST_DONE;
        adj_new        = 1'b0;
        deg_new        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    // new vertex count: recompute the average from scratch
                    dvd_next     = {edge_reg, 1'b0};
                    avg_q_next   = '0;
                    avg_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
                else if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                            edge_next  = '0;
                            max_next   = '0;
                            loop_next  = '0;
                            avg_q_next = '0;
                            avg_r_next = '0;
                        end

                        CMD_QUERY_DEG:
                        begin
                            if (a_ok)
                            begin
                                deg_new = word_a.degree;
                                adj_new = b_ok && bit_ab;
                            end
                            else
                            begin
                                status_new = ST_RANGE;
                            end
                        end

                        default:
                        begin
                            if (!(a_ok && b_ok))
                            begin
                                status_new = ST_RANGE;
                                deg_new    = a_ok ? word_a.degree : '0;
                            end
                            else if (cmd_reg == CMD_QUERY_ADJ)
                            begin
                                adj_new = bit_ab;
                                deg_new = word_a.degree;
                            end
                            else if (bit_ab)
                            begin
                                status_new = ST_DUPLICATE;
                                adj_new    = 1'b1;
                                deg_new    = word_a.degree;
                            end
                            else
                            begin
                                // new edge: write row a now, row b next cycle unless it is a self loop
                                ram_we            = 1'b1;
                                valid_next[a_idx] = 1'b1;
                                edge_next         = edge_reg + EDGE_W'(1);
                                max_next          = max_add;
                                avg_q_next        = inc_q;
                                avg_r_next        = inc_t2[CNT_W-1:0];
                                adj_new           = 1'b1;
                                deg_new           = deg_a_inc;
                                if (a_reg == b_reg)
                                begin
                                    loop_next = loop_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    state_next = S_WRB;
                                end
                            end
                        end
                    endcase
                end
            end

            S_WRB:
            begin
                ram_we            = 1'b1;
                ram_waddr         = b_idx;
                ram_wdata         = word_b_new;
                valid_next[b_idx] = 1'b1;
                state_next        = S_IDLE;
            end

            S_DIV:
            begin
                if (cfg_we)
                begin
                    dvd_next     = {edge_reg, 1'b0};
                    avg_q_next   = '0;
                    avg_r_next   = '0;
                    div_cnt_next = '0;
                end
                else
                begin
                    avg_r_next   = div_rem[CNT_W-1:0];
                    avg_q_next   = {avg_q_reg[DIVD_W-2:0], div_ge};
                    dvd_next     = {dvd_reg[DIVD_W-2:0], 1'b0};
                    div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIVD_W - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            edge_reg      <= '0;
            max_reg       <= '0;
            loop_reg      <= '0;
            vcount_reg    <= CNT_W'(64);
            out_valid_reg <= 1'b0;
            avg_q_reg     <= '0;
            avg_r_reg     <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            edge_reg      <= edge_next;
            max_reg       <= max_next;
            loop_reg      <= loop_next;
            out_valid_reg <= out_valid_next;
            avg_q_reg     <= avg_q_next;
            avg_r_reg     <= avg_r_next;
            div_cnt_reg   <= div_cnt_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        if (ram_re)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            a_reg   <= req.vertex_a;
            b_reg   <= req.vertex_b;
        end
        if (load_out)
        begin
            status_reg   <= status_new;
            adj_reg      <= adj_new;
            deg_reg      <= deg_new;
            edge_out_reg <= edge_next;
            max_out_reg  <= max_next;
            loop_out_reg <= loop_next;
            avg_out_reg  <= avg_sat;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.are_adjacent    = adj_reg;
    assign rsp.degree_of_a     = deg_reg;
    assign rsp.edge_total      = edge_out_reg;
    assign rsp.max_degree      = max_out_reg;
    assign rsp.self_loop_total = loop_out_reg;
    assign rsp.average_degree  = avg_out_reg;

endmodule

>>> tb/sv/undirected_graph_adjacency_store_top_tb.sv
// self-checking testbench of the undirected graph adjacency store: directed and random requests,
// a shadow copy of the graph predicts every response, compared field by field
// depends on ugas_pkg, ugas_if and the rtl of undirected_graph_adjacency_store_top
module undirected_graph_adjacency_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ugas_pkg::*;

    // room for the slowest requests with both sides stalling, ~1400 requests,
    // plus a divide after every vertex count write
    localparam int CYCLE_LIMIT   = 500000;
    // slack for the block to return to idle before a register write
    localparam int SETTLE_CYCLES = 8;

    // one expected response
    typedef struct packed {
        status_t           status;
        logic              are_adjacent;
        logic [CNT_W-1:0]  degree_of_a;
        logic [EDGE_W-1:0] edge_total;
        logic [CNT_W-1:0]  max_degree;
        logic [CNT_W-1:0]  self_loop_total;
        logic [AVG_W-1:0]  average_degree;
    } graph_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    ugas_req_if req_ch();
    ugas_rsp_if rsp_ch();

    undirected_graph_adjacency_store_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the graph, kept in step with every accepted request
    logic [ROWS_USED-1:0] shadow_rows [ROWS_USED];
    int unsigned          shadow_deg  [ROWS_USED];
    int unsigned          shadow_edges;
    int unsigned          shadow_max;
    int unsigned          shadow_loops;
    int unsigned          shadow_vcount;

    // responses still owed by the block, oldest first
    graph_result_t pending_results [$];

    int     fail_count  = 0;
    longint cycle_count = 0;
    // both sides stall at random while this is set
    bit     idle_on     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_to(int unsigned v, int unsigned top);
        return (v > top) ? top : v;
    endfunction

    // vertex count as the block uses it: 0 acts as 1, capped at the row count
    function automatic int unsigned live_vertices();
        int unsigned n;
        n = shadow_vcount;
        if (n < 1)
            n = 1;
        if (n > ROWS_USED)
            n = ROWS_USED;
        return n;
    endfunction

    function automatic void graph_clear();
        foreach (shadow_rows[i])
        begin
            shadow_rows[i] = '0;
            shadow_deg[i]  = 0;
        end
        shadow_edges = 0;
        shadow_max   = 0;
        shadow_loops = 0;
    endfunction

    // apply one request to the shadow graph and return the response it should give
    function automatic graph_result_t graph_apply(cmd_t c, logic [VTX_W-1:0] a,
                                                  logic [VTX_W-1:0] b);
        graph_result_t r;
        int unsigned   n;
        bit            a_ok;
        bit            b_ok;
        n    = live_vertices();
        a_ok = a < n;
        b_ok = b < n;
        r.status = ST_DONE;
        if (c == CMD_CLEAR)
            graph_clear();
        else if (c == CMD_QUERY_DEG)
        begin
            if (!a_ok)
                r.status = ST_RANGE;
        end
        else if (!a_ok || !b_ok)
            r.status = ST_RANGE;
        else if (c == CMD_ADD)
        begin
            if (shadow_rows[a][b])
                r.status = ST_DUPLICATE;
            else
            begin
                // a self loop sets one bit and counts once toward the degree
                shadow_rows[a][b] = 1'b1;
                shadow_rows[b][a] = 1'b1;
                shadow_deg[a]++;
                if (a != b)
                    shadow_deg[b]++;
                else
                    shadow_loops++;
                shadow_edges++;
                if (shadow_deg[a] > shadow_max)
                    shadow_max = shadow_deg[a];
                if (shadow_deg[b] > shadow_max)
                    shadow_max = shadow_deg[b];
            end
        end
        r.are_adjacent    = (a_ok && b_ok) ? shadow_rows[a][b] : 1'b0;
        r.degree_of_a     = a_ok ? CNT_W'(clamp_to(shadow_deg[a], 127)) : '0;
        r.edge_total      = EDGE_W'(clamp_to(shadow_edges, 4095));
        r.max_degree      = CNT_W'(clamp_to(shadow_max, 127));
        r.self_loop_total = CNT_W'(clamp_to(shadow_loops, 127));
        r.average_degree  = AVG_W'(clamp_to((2 * shadow_edges) / n, 255));
        return r;
    endfunction

    // present one request and hold it until accepted; valid stays high afterwards
    // so back-to-back requests need no gap
    task automatic send_request(cmd_t c, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
        graph_result_t expected;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.vertex_a <= a;
        req_ch.vertex_b <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected        = graph_apply(c, a, b);
        pending_results = {pending_results, expected};
    endtask

    // drop valid and wait until every owed response is back, then let the pipe settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic set_vertex_count(logic [CNT_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_vcount = v;
    endtask

    // mostly in-range vertices so the graph actually fills, with some stray ones
    function automatic logic [VTX_W-1:0] pick_vertex();
        if ($urandom_range(0, 9) != 0)
            return VTX_W'($urandom_range(0, live_vertices() - 1));
        return VTX_W'($urandom_range(0, 63));
    endfunction

    // ---------------------------------------------------------------- tests

    // edge extremes, duplicates both ways, self loops, clear, at reset vertex count
    task automatic test_basic_commands();
        send_request(CMD_QUERY_ADJ, 6'd0, 6'd63);
        send_request(CMD_ADD, 6'd0, 6'd63);
        send_request(CMD_ADD, 6'd63, 6'd0);
        send_request(CMD_ADD, 6'd0, 6'd63);
        send_request(CMD_ADD, 6'd63, 6'd63);
        send_request(CMD_ADD, 6'd63, 6'd63);
        send_request(CMD_QUERY_ADJ, 6'd63, 6'd0);
        send_request(CMD_QUERY_ADJ, 6'd0, 6'd0);
        send_request(CMD_QUERY_DEG, 6'd63, 6'd0);
        send_request(CMD_QUERY_DEG, 6'd0, 6'd63);
        send_request(CMD_ADD, 6'd42, 6'd21);
        send_request(CMD_QUERY_DEG, 6'd21, 6'd42);
        // clear ignores its vertex fields
        send_request(CMD_CLEAR, 6'd63, 6'd63);
        send_request(CMD_QUERY_ADJ, 6'd0, 6'd63);
        send_request(CMD_QUERY_DEG, 6'd63, 6'd0);
        send_request(CMD_ADD, 6'd0, 6'd0);
        drain_results();
    endtask

    // range checks at small, zero, oversized and odd vertex counts
    task automatic test_vertex_count_limits();
        set_vertex_count(7'd1);
        send_request(CMD_ADD, 6'd0, 6'd1);
        send_request(CMD_ADD, 6'd1, 6'd0);
        send_request(CMD_QUERY_ADJ, 6'd0, 6'd0);
        send_request(CMD_QUERY_DEG, 6'd1, 6'd0);
        send_request(CMD_QUERY_DEG, 6'd0, 6'd1);
        // zero behaves as one vertex
        set_vertex_count(7'd0);
        send_request(CMD_QUERY_DEG, 6'd0, 6'd0);
        send_request(CMD_ADD, 6'd0, 6'd0);
        send_request(CMD_QUERY_ADJ, 6'd0, 6'd63);
        // anything above the row count is capped
        set_vertex_count(7'd127);
        send_request(CMD_ADD, 6'd63, 6'd62);
        send_request(CMD_QUERY_DEG, 6'd63, 6'd62);
        // edge 63-62 is now outside the graph but still counted in the totals
        set_vertex_count(7'd37);
        send_request(CMD_QUERY_ADJ, 6'd36, 6'd37);
        send_request(CMD_ADD, 6'd36, 6'd0);
        send_request(CMD_ADD, 6'd37, 6'd0);
        send_request(CMD_QUERY_DEG, 6'd37, 6'd0);
        send_request(CMD_CLEAR, 6'd40, 6'd50);
        set_vertex_count(7'd64);
    endtask

    // fill until twice the edge count exceeds the 8-bit average, then shrink the vertex count so the average saturates;
    // vertex 0 gets every neighbor plus its loop for the largest degree
    task automatic test_average_saturation();
        send_request(CMD_CLEAR, 6'd0, 6'd0);
        for (int j = 0; j < 64; j++)
            send_request(CMD_ADD, 6'd0, VTX_W'(j));
        for (int j = 2; j < 64; j++)
            send_request(CMD_ADD, 6'd1, VTX_W'(j));
        for (int j = 3; j < 6; j++)
            send_request(CMD_ADD, 6'd2, VTX_W'(j));
        set_vertex_count(7'd1);
        send_request(CMD_QUERY_DEG, 6'd0, 6'd0);
        send_request(CMD_QUERY_ADJ, 6'd0, 6'd0);
        send_request(CMD_QUERY_DEG, 6'd5, 6'd0);
        set_vertex_count(7'd2);
        send_request(CMD_QUERY_DEG, 6'd1, 6'd0);
        set_vertex_count(7'd64);
        send_request(CMD_QUERY_DEG, 6'd0, 6'd1);
        send_request(CMD_CLEAR, 6'd0, 6'd0);
    endtask

    // random mix weighted toward adds; clears are rare so the graph builds up
    task automatic test_random_traffic(int count);
        cmd_t             c;
        int unsigned      roll;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                c = CMD_ADD;
            else if (roll < 75)
                c = CMD_QUERY_ADJ;
            else if (roll < 97)
                c = CMD_QUERY_DEG;
            else
                c = CMD_CLEAR;
            a = pick_vertex();
            // self loops now and then
            b = ($urandom_range(0, 9) == 0) ? a : pick_vertex();
            send_request(c, a, b);
        end
    endtask

    // sender stops until the block has answered everything, then resumes
    task automatic test_pause_and_resume();
        repeat (4)
        begin
            test_random_traffic(12);
            drain_results();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_ADD;
        req_ch.vertex_a <= '0;
        req_ch.vertex_b <= '0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        graph_clear();
        shadow_vcount = 64;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_basic_commands();
        idle_on = 1'b1;
        test_vertex_count_limits();
        test_average_saturation();
        test_random_traffic(300);
        // small dense graph: duplicates and adjacency hits become common
        set_vertex_count(7'd8);
        test_random_traffic(200);
        set_vertex_count(7'($urandom_range(1, 64)));
        test_random_traffic(200);
        test_pause_and_resume();
        set_vertex_count(7'd127);
        test_random_traffic(120);
        set_vertex_count(7'd0);
        test_random_traffic(50);
        // closing stretch at full rate on both sides
        set_vertex_count(7'd64);
        idle_on = 1'b0;
        test_random_traffic(250);

        drain_results();
        if (fail_count == 0)
            $display("undirected_graph_adjacency_store_top: match");
        else
            $display("undirected_graph_adjacency_store_top: mismatch");
        $finish;
    end

    // response side: ready high, with random stall bursts while idling is on
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 6) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(posedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // every accepted response is matched against the oldest owed one
    always @(posedge clk)
    begin
        graph_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: response expected none actual status %0d edges %0d",
                         $time, rsp_ch.status, rsp_ch.edge_total);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, rsp_ch.status);
                compare_field("are_adjacent", want.are_adjacent, rsp_ch.are_adjacent);
                compare_field("degree_of_a", want.degree_of_a, rsp_ch.degree_of_a);
                compare_field("edge_total", want.edge_total, rsp_ch.edge_total);
                compare_field("max_degree", want.max_degree, rsp_ch.max_degree);
                compare_field("self_loop_total", want.self_loop_total,
                              rsp_ch.self_loop_total);
                compare_field("average_degree", want.average_degree,
                              rsp_ch.average_degree);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("undirected_graph_adjacency_store_top: mismatch");
            $finish;
        end
    end

endmodule
